>>> rtl/key_sequence_gap_filler_assert.svh
// Assertion macros used by the gap filler back end.
// Needs nothing else; included by ksgf_back, which checks its own logic.
`ifndef KEY_SEQUENCE_GAP_FILLER_ASSERT_SVH
`define KEY_SEQUENCE_GAP_FILLER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define KSGF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define KSGF_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/ksgf_pkg.sv
// Types and constants of the key sequence gap filler.
// Used by the front, the back end and the top level.
package ksgf_pkg;

   localparam int TAG_W     = 16;
   localparam int INC_W     = 16;
   localparam int CSR_IDX_W = 3;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_INCREMENT = 3'd0;
   localparam csr_idx_type CSR_MIN_VALUE = 3'd1;
   localparam csr_idx_type CSR_MIN_GIVEN = 3'd2;
   localparam csr_idx_type CSR_MAX_VALUE = 3'd3;
   localparam csr_idx_type CSR_MAX_GIVEN = 3'd4;

   typedef enum logic [1:0] {
      CMD_FIRST,
      CMD_TRACE,
      CMD_ERR,
      CMD_END
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ORDER = 2'd1,
      ST_RUN   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_SKIP,
      PH_RUN,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FIRST,
      BK_ARRIVE,
      BK_CHECK,
      BK_WALK,
      BK_FAIL
   } bk_state_type;

   typedef struct packed {
      logic       is_pad;
      status_type status;
      logic       run_end;
   } rsp_meta_type;

endpackage

>>> rtl/key_sequence_gap_filler.sv
// Key sequence gap filler: a request is a trace (key, tag) or an end of
// stream; each response is a pad or a passed trace on a grid of keys that
// starts at the minimum and steps by the increment, or an error that halts the
// block until reset. The front end takes one request per cycle, unless the
// queue is full, into a two-entry queue; the back end walks a trace through
// idle, arrive, check and walk (the first also through first), an end of
// stream through idle, check and walk, with one walk step per pad. Responses
// leave through an output register; the queue keeps filling while one waits.
// Depends on ksgf_pkg, ksgf_front, ksgf_queue and ksgf_back.
module key_sequence_gap_filler #(
   parameter int MAX_RUN  = 64,
   parameter int KEY_BITS = 32,
   localparam int REQ_W   = ((KEY_BITS + ksgf_pkg::TAG_W + 7) / 8) * 8,
   localparam int RSP_W   = ((KEY_BITS + ksgf_pkg::TAG_W + 2 + 7) / 8) * 8,
   localparam int CSR_W   = (KEY_BITS > ksgf_pkg::INC_W) ? KEY_BITS : ksgf_pkg::INC_W
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = key, trace_tag; tuser = req_type
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [REQ_W-1:0]                req_tdata,
   input  logic                            req_tuser,
   // response: tdata = out_key, header_src, status; tuser = is_pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [RSP_W-1:0]                rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [ksgf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]                csr_wdata
);
   import ksgf_pkg::*;

   localparam int QW = 2 + TAG_W + KEY_BITS;

   logic [INC_W-1:0]    increment_ff;
   logic [KEY_BITS-1:0] min_value_ff;
   logic                min_given_ff;
   logic [KEY_BITS-1:0] max_value_ff;
   logic                max_given_ff;

   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   cmd_kind_type        front_kind;
   logic [QW-1:0]       q_wdata;
   logic [QW-1:0]       q_rdata;
   logic [KEY_BITS-1:0] rsp_key;
   logic [TAG_W-1:0]    rsp_tag;
   rsp_meta_type        rsp_meta;

   always_ff @(posedge clock) begin
      if (reset) begin
         increment_ff <= INC_W'(1);
         min_value_ff <= '0;
         min_given_ff <= 1'b0;
         max_value_ff <= '0;
         max_given_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INCREMENT: increment_ff <= csr_wdata[INC_W-1:0];
            CSR_MIN_VALUE: min_value_ff <= csr_wdata[KEY_BITS-1:0];
            CSR_MIN_GIVEN: min_given_ff <= csr_wdata[0];
            CSR_MAX_VALUE: max_value_ff <= csr_wdata[KEY_BITS-1:0];
            CSR_MAX_GIVEN: max_given_ff <= csr_wdata[0];
            default: begin
               increment_ff <= increment_ff;
            end
         endcase
      end
   end

   ksgf_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_end    (req_tuser),
      .req_key    (req_tdata[KEY_BITS-1:0]),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_kind     (front_kind)
   );

   assign q_wdata = {front_kind, req_tdata[KEY_BITS+TAG_W-1:KEY_BITS],
                     req_tdata[KEY_BITS-1:0]};

   ksgf_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   ksgf_back #(
      .MAX_RUN  (MAX_RUN),
      .KEY_BITS (KEY_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .increment  (increment_ff),
      .min_value  (min_value_ff),
      .min_given  (min_given_ff),
      .max_value  (max_value_ff),
      .max_given  (max_given_ff),
      .cmd_valid  (q_valid),
      .cmd_kind   (cmd_kind_type'(q_rdata[QW-1:QW-2])),
      .cmd_key    (q_rdata[KEY_BITS-1:0]),
      .cmd_tag    (q_rdata[KEY_BITS+TAG_W-1:KEY_BITS]),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_key    (rsp_key),
      .rsp_tag    (rsp_tag),
      .rsp_meta   (rsp_meta)
   );

   assign rsp_tdata = RSP_W'({rsp_meta.status, rsp_tag, rsp_key});
   assign rsp_tuser = rsp_meta.is_pad;
   assign rsp_tlast = rsp_meta.run_end;

endmodule

>>> rtl/ksgf_front.sv
// Front end: accepts requests and classifies them (first trace, trace,
// order error, end of stream). Depends on ksgf_pkg.
module ksgf_front #(
   parameter int KEY_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_end,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic                   q_full,
   output logic                   q_push,
   output ksgf_pkg::cmd_kind_type q_kind
);
   import ksgf_pkg::*;

   logic                seen_ff, seen_in;
   logic [KEY_BITS-1:0] prev_key_ff, prev_key_in;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      if (req_end) begin
         q_kind = CMD_END;
      end else if (!seen_ff) begin
         q_kind = CMD_FIRST;
      end else if ($signed(req_key) <= $signed(prev_key_ff)) begin
         q_kind = CMD_ERR;
      end else begin
         q_kind = CMD_TRACE;
      end
   end

   always_comb begin
      seen_in     = seen_ff | q_push;
      prev_key_in = prev_key_ff;
      if (q_push && !req_end && q_kind != CMD_ERR) begin
         prev_key_in = req_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         prev_key_ff <= '0;
      end else begin
         seen_ff     <= seen_in;
         prev_key_ff <= prev_key_in;
      end
   end

endmodule

>>> rtl/ksgf_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on nothing but its width parameter.
module ksgf_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/ksgf_back.sv
// Back end: walks the key grid, emits pads and traces into the response
// register, detects long runs and order errors, and halts on either. Depends on ksgf_pkg.
`include "key_sequence_gap_filler_assert.svh"

module ksgf_back #(
   parameter int MAX_RUN  = 64,
   parameter int KEY_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ksgf_pkg::INC_W-1:0]  increment,
   input  logic [KEY_BITS-1:0]         min_value,
   input  logic                        min_given,
   input  logic [KEY_BITS-1:0]         max_value,
   input  logic                        max_given,
   input  logic                        cmd_valid,
   input  ksgf_pkg::cmd_kind_type      cmd_kind,
   input  logic [KEY_BITS-1:0]         cmd_key,
   input  logic [ksgf_pkg::TAG_W-1:0]  cmd_tag,
   output logic                        cmd_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [KEY_BITS-1:0]         rsp_key,
   output logic [ksgf_pkg::TAG_W-1:0]  rsp_tag,
   output ksgf_pkg::rsp_meta_type      rsp_meta
);
   import ksgf_pkg::*;

   localparam int NW = ((KEY_BITS > INC_W) ? KEY_BITS : INC_W) + 2;
   localparam int TW = INC_W + $clog2(MAX_RUN + 1);
   localparam int CW = ((NW > TW) ? NW : TW) + 1;
   localparam logic signed [NW-1:0] KEY_INF =
      {{(NW-KEY_BITS-1){1'b0}}, 1'b1, {KEY_BITS{1'b0}}};

   bk_state_type             state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic                     halted_ff, halted_in;
   logic signed [NW-1:0]     ne_ff, ne_in;
   logic signed [NW-1:0]     ne2_ff, ne2_in;
   logic signed [NW-1:0]     lim_ff, lim_in;
   logic [TAG_W-1:0]         tag_ff, tag_in;
   logic [TAG_W-1:0]         last_tag_ff, last_tag_in;
   logic                     pad_mode_ff, pad_mode_in;
   status_type               fail_st_ff, fail_st_in;
   logic [TW-1:0]            thr_full_ff, thr_full_in;
   logic [TW-1:0]            thr_arr_ff, thr_arr_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]      rsp_key_ff, rsp_key_in;
   logic [TAG_W-1:0]         rsp_tag_ff, rsp_tag_in;
   rsp_meta_type             rsp_meta_ff, rsp_meta_in;

   logic [INC_W-1:0]         inc_eff;
   logic signed [NW-1:0]     inc_w;
   logic signed [NW-1:0]     maxv_w;
   logic signed [NW-1:0]     minv_w;
   logic signed [NW-1:0]     key_w;
   logic signed [NW-1:0]     sum_a;
   logic signed [NW-1:0]     sum_w;
   logic signed [NW-1:0]     sat_w;
   logic signed [CW-1:0]     lim_c;
   logic signed [CW-1:0]     ne_c;
   logic signed [CW-1:0]     diff_w;
   logic signed [CW-1:0]     thr_full_c;
   logic signed [CW-1:0]     thr_arr_c;
   logic                     ne_le_lim;
   logic                     ne_lt_lim;
   logic                     run_fail;
   logic                     walk_last;
   logic                     drop_item;
   logic                     out_free;
   logic                     load;

   assign inc_eff    = (increment == '0) ? INC_W'(1) : increment;
   assign inc_w      = {{(NW-INC_W){1'b0}}, inc_eff};
   assign maxv_w     = max_given ? {{(NW-KEY_BITS){max_value[KEY_BITS-1]}}, max_value}
                                 : KEY_INF;
   assign minv_w     = min_given ? {{(NW-KEY_BITS){min_value[KEY_BITS-1]}}, min_value}
                                 : lim_ff;
   assign key_w      = {{(NW-KEY_BITS){cmd_key[KEY_BITS-1]}}, cmd_key};
   assign sum_a      = (state_ff == BK_CHECK) ? ne_ff : ne2_ff;
   assign sum_w      = sum_a + inc_w;
   assign sat_w      = (sum_w > KEY_INF) ? KEY_INF : sum_w;
   assign lim_c      = {{(CW-NW){lim_ff[NW-1]}}, lim_ff};
   assign ne_c       = {{(CW-NW){ne_ff[NW-1]}}, ne_ff};
   assign diff_w     = lim_c - ne_c;
   assign thr_full_c = {{(CW-TW){1'b0}}, thr_full_ff};
   assign thr_arr_c  = {{(CW-TW){1'b0}}, thr_arr_ff};
   assign ne_le_lim  = (ne_ff <= lim_ff);
   assign ne_lt_lim  = (ne_ff < lim_ff);
   assign run_fail   = pad_mode_ff ? (ne_le_lim && diff_w >= thr_full_c)
                                   : (ne_lt_lim && diff_w > thr_arr_c);
   assign walk_last  = pad_mode_ff ? (ne2_ff > lim_ff) : !ne_lt_lim;
   assign drop_item  = halted_ff || (phase_ff == PH_DONE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign thr_full_in = TW'(inc_eff) * TW'(MAX_RUN);
   assign thr_arr_in  = TW'(inc_eff) * TW'(MAX_RUN - 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && !drop_item) begin
               case (cmd_kind)
                  CMD_ERR:   state_in = BK_FAIL;
                  CMD_END:   state_in = (phase_ff == PH_WAIT) ? BK_IDLE : BK_CHECK;
                  CMD_FIRST: state_in = BK_FIRST;
                  CMD_TRACE: state_in = BK_ARRIVE;
                  default:   state_in = BK_IDLE;
               endcase
            end
         end
         BK_FIRST: begin
            state_in = (minv_w > maxv_w) ? BK_IDLE : BK_ARRIVE;
         end
         BK_ARRIVE: begin
            state_in = (phase_ff == PH_SKIP && lim_ff < ne_ff) ? BK_IDLE : BK_CHECK;
         end
         BK_CHECK: begin
            if (run_fail) begin
               state_in = BK_FAIL;
            end else if (pad_mode_ff && !ne_le_lim) begin
               state_in = BK_IDLE;
            end else begin
               state_in = BK_WALK;
            end
         end
         BK_WALK: begin
            if (out_free && walk_last) begin
               state_in = BK_IDLE;
            end
         end
         BK_FAIL: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      halted_in   = halted_ff;
      ne_in       = ne_ff;
      ne2_in      = ne2_ff;
      lim_in      = lim_ff;
      tag_in      = tag_ff;
      last_tag_in = last_tag_ff;
      pad_mode_in = pad_mode_ff;
      fail_st_in  = fail_st_ff;
      cmd_pop     = 1'b0;
      load        = 1'b0;
      rsp_key_in  = rsp_key_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_meta_in = rsp_meta_ff;
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid && !drop_item) begin
               case (cmd_kind)
                  CMD_ERR: begin
                     fail_st_in = ST_ORDER;
                  end
                  CMD_END: begin
                     if (phase_ff == PH_WAIT) begin
                        phase_in = PH_DONE;
                     end else begin
                        if (max_given) begin
                           lim_in = maxv_w;
                        end else if (phase_ff == PH_SKIP) begin
                           lim_in = ne_ff;
                        end else begin
                           lim_in = ne_ff - NW'(1);
                        end
                        pad_mode_in = 1'b1;
                        tag_in      = last_tag_ff;
                     end
                  end
                  default: begin
                     lim_in      = key_w;
                     tag_in      = cmd_tag;
                     last_tag_in = cmd_tag;
                     pad_mode_in = 1'b0;
                  end
               endcase
            end
         end
         BK_FIRST: begin
            if (minv_w > maxv_w) begin
               phase_in = PH_DONE;
            end else begin
               ne_in    = minv_w;
               phase_in = PH_SKIP;
            end
         end
         BK_ARRIVE: begin
            if (!(phase_ff == PH_SKIP && lim_ff < ne_ff)) begin
               phase_in = PH_RUN;
               if (lim_ff > maxv_w) begin
                  lim_in      = maxv_w;
                  pad_mode_in = 1'b1;
               end
            end
         end
         BK_CHECK: begin
            ne2_in = sat_w;
            if (run_fail) begin
               fail_st_in = ST_RUN;
            end else if (pad_mode_ff && !ne_le_lim) begin
               phase_in = PH_DONE;
            end
         end
         BK_WALK: begin
            if (out_free) begin
               load                = 1'b1;
               rsp_meta_in.is_pad  = pad_mode_ff || ne_lt_lim;
               rsp_meta_in.status  = ST_OK;
               rsp_meta_in.run_end = walk_last;
               rsp_key_in          = (pad_mode_ff || ne_lt_lim) ? ne_ff[KEY_BITS-1:0]
                                                                : lim_ff[KEY_BITS-1:0];
               rsp_tag_in          = tag_ff;
               ne_in               = ne2_ff;
               ne2_in              = sat_w;
               if (walk_last && pad_mode_ff) begin
                  phase_in = PH_DONE;
               end
            end
         end
         BK_FAIL: begin
            if (out_free) begin
               load                = 1'b1;
               rsp_meta_in.is_pad  = 1'b0;
               rsp_meta_in.status  = fail_st_ff;
               rsp_meta_in.run_end = 1'b1;
               rsp_key_in          = '0;
               rsp_tag_in          = '0;
               halted_in           = 1'b1;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         phase_ff     <= PH_WAIT;
         halted_ff    <= 1'b0;
         ne_ff        <= '0;
         ne2_ff       <= '0;
         last_tag_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         halted_ff    <= halted_in;
         ne_ff        <= ne_in;
         ne2_ff       <= ne2_in;
         last_tag_ff  <= last_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff      <= lim_in;
      tag_ff      <= tag_in;
      pad_mode_ff <= pad_mode_in;
      fail_st_ff  <= fail_st_in;
      thr_full_ff <= thr_full_in;
      thr_arr_ff  <= thr_arr_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_meta_ff <= rsp_meta_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_key    = rsp_key_ff;
   assign rsp_tag    = rsp_tag_ff;
   assign rsp_meta   = rsp_meta_ff;

   `KSGF_ASSERT_NEVER(a_halt_silent, clock, reset, halted_ff && load, "result after halt")
   `KSGF_ASSERT(a_done_sticky, clock, reset, (phase_ff == PH_DONE) |=> (phase_ff == PH_DONE), "finished stream restarted")
   `KSGF_ASSERT(a_err_halts, clock, reset, (rsp_valid_ff && rsp_meta_ff.status != ST_OK) |-> halted_ff, "error result without halt")
   `KSGF_ASSERT(a_grid_forward, clock, reset, (state_ff == BK_WALK && load) |=> (ne_ff >= $past(ne_ff)), "grid moved backward")

endmodule
